[hw/rtl/pdf_pkg.sv]
// Package for the Pareto dominance filter: sizes, codes, states and control structs.
package pdf_pkg;

   localparam int DEF_MAX_POINTS     = 64;
   localparam int DEF_MAX_OBJECTIVES = 8;
   localparam int DEF_COORD_WIDTH    = 32;

   localparam int FUNC_WIDTH  = 2;
   localparam int ID_WIDTH    = 6;
   localparam int OBJ_IDX_W   = 3;
   localparam int IN_COORD_W  = 32;
   localparam int START_WIDTH = 6;
   localparam int END_WIDTH   = 7;
   localparam int IDX_WIDTH   = 8;
   localparam int CFG_WIDTH   = 4;

   localparam logic [CFG_WIDTH-1:0] OBJ_COUNT_RESET = 4'd2;

   localparam logic [FUNC_WIDTH-1:0] FUNC_LOAD_IDEAL = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_LOAD_POINT = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_RUN        = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMPTY_OUT,
      ST_A_RD,
      ST_A_LD,
      ST_PAIR_CHK,
      ST_I_CHK,
      ST_B_LD,
      ST_CMP,
      ST_DRAIN,
      ST_DECIDE,
      ST_FIX_I,
      ST_FIX_I2,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   typedef enum logic [1:0] {
      SEL_I,
      SEL_I2,
      SEL_END
   } slot_sel_type;

   typedef struct packed {
      logic         load_en;
      logic         run_init;
      logic         slot_rd;
      slot_sel_type slot_sel;
      logic         slot_wr;
      logic         load_a;
      logic         load_b;
      logic         cmp_clear;
      logic         cmp_issue;
      logic         end_dec;
      logic         i_inc;
      logic         i2_inc;
      logic         i2_from_i;
      logic         k_init;
      logic         out_load;
      logic         out_empty;
   } ctrl_cmd_type;

   typedef struct packed {
      logic range_empty;
      logic i_gt_end;
      logic i2_gt_end;
      logic k_last;
      logic j_done;
      logic pipe_busy;
      logic better;
      logic worse;
      logic out_free;
   } dp_status_type;

endpackage

[hw/rtl/pdf_req_if.sv]
// Request channel interface of the Pareto dominance filter.
interface pdf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [pdf_pkg::FUNC_WIDTH-1:0]  func;
   logic        [pdf_pkg::ID_WIDTH-1:0]    point_index;
   logic        [pdf_pkg::OBJ_IDX_W-1:0]   objective_index;
   logic signed [pdf_pkg::IN_COORD_W-1:0]  coord_value;
   logic        [pdf_pkg::START_WIDTH-1:0] range_start;
   logic signed [pdf_pkg::END_WIDTH-1:0]   range_end;

   modport source (
      output valid, func, point_index, objective_index, coord_value, range_start, range_end,
      input  ready
   );
   modport sink (
      input  valid, func, point_index, objective_index, coord_value, range_start, range_end,
      output ready
   );
endinterface

[hw/rtl/pdf_rsp_if.sv]
// Response channel interface of the Pareto dominance filter.
interface pdf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [pdf_pkg::ID_WIDTH-1:0]  survivor_id;
   logic signed [pdf_pkg::END_WIDTH-1:0] new_range_end;
   logic                                 empty_range;
   logic                                 last_result;

   modport source (
      output valid, survivor_id, new_range_end, empty_range, last_result,
      input  ready
   );
   modport sink (
      input  valid, survivor_id, new_range_end, empty_range, last_result,
      output ready
   );
endinterface

[hw/rtl/pdf_datapath.sv]
// Datapath of the Pareto dominance filter: memories, walk indices, compare pipe, output reg.
module pdf_datapath #(
   parameter int MAX_POINTS     = pdf_pkg::DEF_MAX_POINTS,
   parameter int MAX_OBJECTIVES = pdf_pkg::DEF_MAX_OBJECTIVES,
   parameter int COORD_WIDTH    = pdf_pkg::DEF_COORD_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pdf_pkg::ctrl_cmd_type                  cmd,
   output pdf_pkg::dp_status_type                 status,
   input  logic        [pdf_pkg::FUNC_WIDTH-1:0]  req_func,
   input  logic        [pdf_pkg::ID_WIDTH-1:0]    req_point_index,
   input  logic        [pdf_pkg::OBJ_IDX_W-1:0]   req_objective_index,
   input  logic signed [pdf_pkg::IN_COORD_W-1:0]  req_coord_value,
   input  logic        [pdf_pkg::START_WIDTH-1:0] req_range_start,
   input  logic signed [pdf_pkg::END_WIDTH-1:0]   req_range_end,
   input  logic                                   csr_write_enable,
   input  logic        [pdf_pkg::CFG_WIDTH-1:0]   csr_write_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [pdf_pkg::ID_WIDTH-1:0]    rsp_survivor_id,
   output logic signed [pdf_pkg::END_WIDTH-1:0]   rsp_new_range_end,
   output logic                                   rsp_empty_range,
   output logic                                   rsp_last_result
);

   localparam int PID_W     = $clog2(MAX_POINTS);
   localparam int OBJ_W     = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
   localparam int CNT_W     = $clog2(MAX_OBJECTIVES + 1);
   localparam int MEM_DEPTH = MAX_POINTS * (2 ** OBJ_W);
   localparam int IW        = pdf_pkg::IDX_WIDTH;

   logic signed [COORD_WIDTH-1:0]       coord_mem [MEM_DEPTH];
   logic        [pdf_pkg::ID_WIDTH-1:0] slot_mem  [MAX_POINTS];
   logic signed [COORD_WIDTH-1:0]       ideal_ff  [MAX_OBJECTIVES];

   logic [pdf_pkg::CFG_WIDTH-1:0] obj_count_ff;
   logic [CNT_W-1:0]              nobj_ff;
   logic [CNT_W-1:0]              j_ff;
   logic signed [IW-1:0]          start_ff, end_ff, i_ff, i2_ff;
   logic [pdf_pkg::ID_WIDTH-1:0]  slot_rd_ff, id_a_ff, id_b_ff;
   logic signed [COORD_WIDTH-1:0] coord_a_ff, coord_b_ff, ideal_q_ff;
   logic signed [COORD_WIDTH-1:0] clip_a_ff, clip_b_ff;
   logic signed [COORD_WIDTH-1:0] clip_a_in, clip_b_in;
   logic                          v1_ff, v2_ff;
   logic                          better_ff, worse_ff;

   logic signed [IW-1:0]          slot_idx;
   logic [PID_W-1:0]              slot_addr;
   logic signed [IW-1:0]          end_ext, end_sat;
   logic [CNT_W-1:0]              nobj_in;
   logic                          obj_ok, pid_ok, load_ideal, load_point;
   logic signed [COORD_WIDTH-1:0] load_coord;
   logic                          out_free;

   logic                                 rsp_valid_ff;
   logic [pdf_pkg::ID_WIDTH-1:0]         rsp_id_ff;
   logic signed [pdf_pkg::END_WIDTH-1:0] rsp_end_ff;
   logic                                 rsp_empty_ff, rsp_last_ff;

   always_comb begin
      obj_ok     = 32'(req_objective_index) < MAX_OBJECTIVES;
      pid_ok     = 32'(req_point_index) < MAX_POINTS;
      load_ideal = cmd.load_en && (req_func == pdf_pkg::FUNC_LOAD_IDEAL) && obj_ok;
      load_point = cmd.load_en && (req_func == pdf_pkg::FUNC_LOAD_POINT) && obj_ok && pid_ok;
      load_coord = COORD_WIDTH'(req_coord_value);
      end_ext    = IW'(req_range_end);
      end_sat    = (int'(req_range_end) > MAX_POINTS - 1) ? IW'(MAX_POINTS - 1) : end_ext;
      nobj_in    = (32'(obj_count_ff) > MAX_OBJECTIVES) ? CNT_W'(MAX_OBJECTIVES)
                                                        : CNT_W'(obj_count_ff);
      unique case (cmd.slot_sel)
         pdf_pkg::SEL_I:   slot_idx = i_ff;
         pdf_pkg::SEL_I2:  slot_idx = i2_ff;
         pdf_pkg::SEL_END: slot_idx = end_ff;
         default:          slot_idx = i_ff;
      endcase
      slot_addr = PID_W'($unsigned(slot_idx));
      clip_a_in = (coord_a_ff < ideal_q_ff) ? coord_a_ff : ideal_q_ff;
      clip_b_in = (coord_b_ff < ideal_q_ff) ? coord_b_ff : ideal_q_ff;
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         obj_count_ff <= pdf_pkg::OBJ_COUNT_RESET;
      end else if (csr_write_enable) begin
         obj_count_ff <= csr_write_data;
      end
   end

   // coordinate and ideal storage
   always_ff @(posedge clock) begin
      if (load_point) begin
         coord_mem[{PID_W'(req_point_index), OBJ_W'(req_objective_index)}] <= load_coord;
      end
      if (load_ideal) begin
         ideal_ff[OBJ_W'(req_objective_index)] <= load_coord;
      end
      if (cmd.cmp_issue) begin
         coord_a_ff <= coord_mem[{PID_W'(id_a_ff), j_ff[OBJ_W-1:0]}];
         coord_b_ff <= coord_mem[{PID_W'(id_b_ff), j_ff[OBJ_W-1:0]}];
         ideal_q_ff <= ideal_ff[j_ff[OBJ_W-1:0]];
      end
      clip_a_ff <= clip_a_in;
      clip_b_ff <= clip_b_in;
   end

   // slot table
   always_ff @(posedge clock) begin
      if (load_point) begin
         slot_mem[PID_W'(req_point_index)] <= req_point_index;
      end else if (cmd.slot_wr) begin
         slot_mem[slot_addr] <= slot_rd_ff;
      end
      if (cmd.slot_rd) begin
         slot_rd_ff <= slot_mem[slot_addr];
      end
   end

   // walk indices and point ids
   always_ff @(posedge clock) begin
      if (cmd.run_init) begin
         start_ff <= IW'(req_range_start);
         i_ff     <= IW'(req_range_start);
         end_ff   <= end_sat;
         nobj_ff  <= nobj_in;
      end
      if (cmd.i_inc) begin
         i_ff <= i_ff + IW'(1);
      end else if (cmd.k_init) begin
         i_ff <= start_ff;
      end
      if (cmd.i2_from_i) begin
         i2_ff <= i_ff + IW'(1);
      end else if (cmd.i2_inc) begin
         i2_ff <= i2_ff + IW'(1);
      end
      if (cmd.end_dec) begin
         end_ff <= end_ff - IW'(1);
      end
      if (cmd.load_a || (cmd.slot_wr && (cmd.slot_sel == pdf_pkg::SEL_I))) begin
         id_a_ff <= slot_rd_ff;
      end
      if (cmd.load_b) begin
         id_b_ff <= slot_rd_ff;
      end
      if (cmd.cmp_clear) begin
         j_ff <= '0;
      end else if (cmd.cmp_issue) begin
         j_ff <= j_ff + CNT_W'(1);
      end
   end

   // compare pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.cmp_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_clear) begin
         better_ff <= 1'b0;
         worse_ff  <= 1'b0;
      end else if (v2_ff) begin
         better_ff <= better_ff || (clip_a_ff > clip_b_ff);
         worse_ff  <= worse_ff || (clip_a_ff < clip_b_ff);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.out_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_empty) begin
         rsp_id_ff    <= '0;
         rsp_end_ff   <= end_ff[pdf_pkg::END_WIDTH-1:0];
         rsp_empty_ff <= 1'b1;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.out_load) begin
         rsp_id_ff    <= slot_rd_ff;
         rsp_end_ff   <= end_ff[pdf_pkg::END_WIDTH-1:0];
         rsp_empty_ff <= 1'b0;
         rsp_last_ff  <= (i_ff == end_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_survivor_id   = rsp_id_ff;
   assign rsp_new_range_end = rsp_end_ff;
   assign rsp_empty_range   = rsp_empty_ff;
   assign rsp_last_result   = rsp_last_ff;

   always_comb begin
      status.range_empty = end_ff < start_ff;
      status.i_gt_end    = i_ff > end_ff;
      status.i2_gt_end   = i2_ff > end_ff;
      status.k_last      = i_ff == end_ff;
      status.j_done      = j_ff == nobj_ff;
      status.pipe_busy   = v1_ff || v2_ff;
      status.better      = better_ff;
      status.worse       = worse_ff;
      status.out_free    = out_free;
   end

endmodule

[hw/rtl/pdf_ctrl.sv]
// Controller state machine of the Pareto dominance filter.
module pdf_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pdf_pkg::FUNC_WIDTH-1:0]  req_func,
   input  pdf_pkg::dp_status_type          status,
   output pdf_pkg::ctrl_cmd_type           cmd
);

   pdf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.slot_sel = pdf_pkg::SEL_I;
      req_ready    = 1'b0;
      unique case (state_ff)
         pdf_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_en = req_valid;
            if (req_valid && (req_func == pdf_pkg::FUNC_RUN)) begin
               cmd.run_init = 1'b1;
               state_in     = pdf_pkg::ST_CHECK;
            end
         end
         pdf_pkg::ST_CHECK: begin
            if (status.range_empty) begin
               state_in = pdf_pkg::ST_EMPTY_OUT;
            end else begin
               state_in = pdf_pkg::ST_A_RD;
            end
         end
         pdf_pkg::ST_EMPTY_OUT: begin
            if (status.out_free) begin
               cmd.out_empty = 1'b1;
               state_in      = pdf_pkg::ST_IDLE;
            end
         end
         pdf_pkg::ST_A_RD: begin
            cmd.slot_rd  = 1'b1;
            cmd.slot_sel = pdf_pkg::SEL_I;
            state_in     = pdf_pkg::ST_A_LD;
         end
         pdf_pkg::ST_A_LD: begin
            cmd.load_a    = 1'b1;
            cmd.i2_from_i = 1'b1;
            state_in      = pdf_pkg::ST_PAIR_CHK;
         end
         pdf_pkg::ST_PAIR_CHK: begin
            if (status.i2_gt_end) begin
               cmd.i_inc = 1'b1;
               state_in  = pdf_pkg::ST_I_CHK;
            end else begin
               cmd.slot_rd  = 1'b1;
               cmd.slot_sel = pdf_pkg::SEL_I2;
               state_in     = pdf_pkg::ST_B_LD;
            end
         end
         pdf_pkg::ST_I_CHK: begin
            if (status.i_gt_end) begin
               cmd.k_init = 1'b1;
               state_in   = pdf_pkg::ST_EMIT_RD;
            end else begin
               state_in = pdf_pkg::ST_A_RD;
            end
         end
         pdf_pkg::ST_B_LD: begin
            cmd.load_b    = 1'b1;
            cmd.cmp_clear = 1'b1;
            state_in      = pdf_pkg::ST_CMP;
         end
         pdf_pkg::ST_CMP: begin
            if (status.j_done) begin
               state_in = pdf_pkg::ST_DRAIN;
            end else begin
               cmd.cmp_issue = 1'b1;
            end
         end
         pdf_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = pdf_pkg::ST_DECIDE;
            end
         end
         pdf_pkg::ST_DECIDE: begin
            priority if (!status.worse) begin
               cmd.slot_rd  = 1'b1;
               cmd.slot_sel = pdf_pkg::SEL_END;
               state_in     = pdf_pkg::ST_FIX_I2;
            end else if (!status.better) begin
               cmd.slot_rd  = 1'b1;
               cmd.slot_sel = pdf_pkg::SEL_END;
               state_in     = pdf_pkg::ST_FIX_I;
            end else begin
               cmd.i2_inc = 1'b1;
               state_in   = pdf_pkg::ST_PAIR_CHK;
            end
         end
         pdf_pkg::ST_FIX_I2: begin
            cmd.slot_wr  = 1'b1;
            cmd.slot_sel = pdf_pkg::SEL_I2;
            cmd.end_dec  = 1'b1;
            cmd.i2_inc   = 1'b1;
            state_in     = pdf_pkg::ST_PAIR_CHK;
         end
         pdf_pkg::ST_FIX_I: begin
            cmd.slot_wr  = 1'b1;
            cmd.slot_sel = pdf_pkg::SEL_I;
            cmd.end_dec  = 1'b1;
            cmd.i2_inc   = 1'b1;
            state_in     = pdf_pkg::ST_PAIR_CHK;
         end
         pdf_pkg::ST_EMIT_RD: begin
            cmd.slot_rd  = 1'b1;
            cmd.slot_sel = pdf_pkg::SEL_I;
            state_in     = pdf_pkg::ST_EMIT_LD;
         end
         pdf_pkg::ST_EMIT_LD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.k_last) begin
                  state_in = pdf_pkg::ST_IDLE;
               end else begin
                  cmd.i_inc = 1'b1;
                  state_in  = pdf_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = pdf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/pareto_dominance_filter.sv]
// Top level of the Pareto dominance filter: controller plus datapath.
//
// Requests arrive on req_if (valid/ready). func 0 loads one ideal coordinate,
// func 1 loads one point coordinate and maps slot point_index to that point,
// func 2 runs the pairwise filter over slots range_start..range_end.
// Loads are taken one per cycle while no run is in progress and give no
// response. A run holds req_if.ready low until its last response has been
// placed in the output register. A run starts with a setup check of the range;
// each pair is then compared serially, one objective a cycle through a
// two-read coordinate memory and a three-stage clip/compare pipe, and each
// survivor is then read out through the single slot table read port.
// Responses leave rsp_if from one output register; when the receiver stalls,
// the run waits, and the next request is accepted while the final response
// still waits. objective_count is written through csr_write_enable/data; the
// user must do so only while idle, as the block itself does not enforce it.
// Reset is synchronous; it clears the controller, the valid flags and
// sets objective_count to 2. Memory contents are undefined until loaded.
module pareto_dominance_filter #(
   parameter int MAX_POINTS     = pdf_pkg::DEF_MAX_POINTS,
   parameter int MAX_OBJECTIVES = pdf_pkg::DEF_MAX_OBJECTIVES,
   parameter int COORD_WIDTH    = pdf_pkg::DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   pdf_req_if.sink                       req_if,
   pdf_rsp_if.source                     rsp_if,
   input  logic                          csr_write_enable,
   input  logic [pdf_pkg::CFG_WIDTH-1:0] csr_write_data
);

   pdf_pkg::ctrl_cmd_type  cmd;
   pdf_pkg::dp_status_type status;
   logic                   ready;

   pdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ready),
      .req_func  (req_if.func),
      .status    (status),
      .cmd       (cmd)
   );

   pdf_datapath #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_OBJECTIVES (MAX_OBJECTIVES),
      .COORD_WIDTH    (COORD_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_if.func),
      .req_point_index     (req_if.point_index),
      .req_objective_index (req_if.objective_index),
      .req_coord_value     (req_if.coord_value),
      .req_range_start     (req_if.range_start),
      .req_range_end       (req_if.range_end),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_survivor_id     (rsp_if.survivor_id),
      .rsp_new_range_end   (rsp_if.new_range_end),
      .rsp_empty_range     (rsp_if.empty_range),
      .rsp_last_result     (rsp_if.last_result)
   );

   assign req_if.ready = ready;

endmodule

[bench/pdf_filter_checker.sv]
// Monitors the filter channels, predicts the surviving point ids and compares each response.
module pdf_filter_checker (
   input  logic                          clock,
   input  logic                          reset,
   pdf_req_if                            req_mon,
   pdf_rsp_if                            rsp_mon,
   input  logic                          csr_write_enable,
   input  logic [pdf_pkg::CFG_WIDTH-1:0] csr_write_data,
   output int                            pending_results,
   output int                            failure_count
);

   localparam int NUM_POINTS = pdf_pkg::DEF_MAX_POINTS;
   localparam int NUM_OBJ    = pdf_pkg::DEF_MAX_OBJECTIVES;
   localparam int REPORT_MAX = 10;
   localparam int END_W      = pdf_pkg::END_WIDTH;

   typedef struct packed {
      logic [pdf_pkg::ID_WIDTH-1:0]         survivor_id;
      logic signed [pdf_pkg::END_WIDTH-1:0] new_range_end;
      logic                                 empty_range;
      logic                                 last_result;
   } survivor_rec_type;

   logic signed [pdf_pkg::IN_COORD_W-1:0] point_coord_mem [NUM_POINTS][NUM_OBJ];
   logic signed [pdf_pkg::IN_COORD_W-1:0] ideal_coord_mem [NUM_OBJ];
   logic [pdf_pkg::ID_WIDTH-1:0]          slot_map [NUM_POINTS];
   logic [pdf_pkg::CFG_WIDTH-1:0]         objective_count;
   survivor_rec_type                      expected_survivors [$];
   int                                    mismatch_tally = 0;

   function automatic logic signed [pdf_pkg::IN_COORD_W-1:0] clipped_coord(
      logic [pdf_pkg::ID_WIDTH-1:0] pid, int obj);
      logic signed [pdf_pkg::IN_COORD_W-1:0] p;
      logic signed [pdf_pkg::IN_COORD_W-1:0] q;
      p = point_coord_mem[pid][obj];
      q = ideal_coord_mem[obj];
      return (p < q) ? p : q;
   endfunction

   task automatic predict_survivors(input int range_first, input int range_last_in);
      int               range_last;
      int               nobj;
      int               i;
      int               i2;
      int               j;
      int               k;
      logic             better;
      logic             worse;
      survivor_rec_type rec;
      range_last = (range_last_in > NUM_POINTS - 1) ? NUM_POINTS - 1 : range_last_in;
      nobj = (objective_count > NUM_OBJ) ? NUM_OBJ : int'(objective_count);
      if (range_last < range_first) begin
         rec.survivor_id   = '0;
         rec.new_range_end = END_W'(range_last);
         rec.empty_range   = 1'b1;
         rec.last_result   = 1'b1;
         expected_survivors.push_back(rec);
         return;
      end
      for (i = range_first; i <= range_last; i++) begin
         for (i2 = i + 1; i2 <= range_last; i2++) begin
            better = 1'b0;
            worse  = 1'b0;
            for (j = 0; j < nobj && !(better && worse); j++) begin
               if (clipped_coord(slot_map[i], j) > clipped_coord(slot_map[i2], j)) better = 1'b1;
               if (clipped_coord(slot_map[i], j) < clipped_coord(slot_map[i2], j)) worse = 1'b1;
            end
            // covered: later slot replaced by the tail; the replacement is not re-compared
            if (!worse) begin
               slot_map[i2] = slot_map[range_last];
               range_last--;
            end
            if (worse && !better) begin
               slot_map[i] = slot_map[range_last];
               range_last--;
            end
         end
      end
      for (k = range_first; k <= range_last; k++) begin
         rec.survivor_id   = slot_map[k];
         rec.new_range_end = END_W'(range_last);
         rec.empty_range   = 1'b0;
         rec.last_result   = (k == range_last);
         expected_survivors.push_back(rec);
      end
   endtask

   task automatic check_response();
      survivor_rec_type want;
      survivor_rec_type got;
      logic             bad;
      got.survivor_id   = rsp_mon.survivor_id;
      got.new_range_end = rsp_mon.new_range_end;
      got.empty_range   = rsp_mon.empty_range;
      got.last_result   = rsp_mon.last_result;
      if (expected_survivors.size() == 0) begin
         mismatch_tally++;
         if (mismatch_tally <= REPORT_MAX)
            $display("%0t: unexpected response id=%0d end=%0d empty=%0b last=%0b", $realtime,
                     got.survivor_id, got.new_range_end, got.empty_range, got.last_result);
         return;
      end
      want = expected_survivors.pop_front();
      bad = (got.new_range_end !== want.new_range_end) || (got.empty_range !== want.empty_range)
         || (got.last_result !== want.last_result)
         || (!want.empty_range && got.survivor_id !== want.survivor_id);
      if (bad) begin
         mismatch_tally++;
         if (mismatch_tally <= REPORT_MAX) begin
            $display("%0t: mismatch expected id=%0d end=%0d empty=%0b last=%0b", $realtime,
                     want.survivor_id, want.new_range_end, want.empty_range, want.last_result);
            $display("%0t: mismatch got      id=%0d end=%0d empty=%0b last=%0b", $realtime,
                     got.survivor_id, got.new_range_end, got.empty_range, got.last_result);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_survivors.delete();
         objective_count = pdf_pkg::OBJ_COUNT_RESET;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_response();
         if (csr_write_enable) objective_count = csr_write_data;
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.func)
               pdf_pkg::FUNC_LOAD_IDEAL: begin
                  ideal_coord_mem[req_mon.objective_index] = req_mon.coord_value;
               end
               pdf_pkg::FUNC_LOAD_POINT: begin
                  point_coord_mem[req_mon.point_index][req_mon.objective_index] =
                     req_mon.coord_value;
                  slot_map[req_mon.point_index] = req_mon.point_index;
               end
               pdf_pkg::FUNC_RUN: begin
                  predict_survivors(int'(req_mon.range_start), int'(req_mon.range_end));
               end
               default: begin
               end
            endcase
         end
      end
      pending_results <= expected_survivors.size();
      failure_count   <= mismatch_tally;
   end

endmodule

[bench/testbench.sv]
// Top of the filter testbench: clock, reset, request stimulus, response pacing and verdict.
module testbench;

   localparam logic [pdf_pkg::FUNC_WIDTH-1:0] FUNC_UNUSED = 2'd3;
   localparam int NUM_POINTS      = pdf_pkg::DEF_MAX_POINTS;
   localparam int NUM_OBJ         = pdf_pkg::DEF_MAX_OBJECTIVES;
   localparam int FILLED_POINTS   = 32;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 24;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES   = 40;
   localparam int QUIET_LIMIT     = 200000;
   localparam int ID_W            = pdf_pkg::ID_WIDTH;
   localparam int OBJ_W           = pdf_pkg::OBJ_IDX_W;
   localparam int START_W         = pdf_pkg::START_WIDTH;
   localparam int END_W           = pdf_pkg::END_WIDTH;
   localparam int CFG_W           = pdf_pkg::CFG_WIDTH;
   localparam logic signed [pdf_pkg::IN_COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [pdf_pkg::IN_COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_write_enable;
   logic [pdf_pkg::CFG_WIDTH-1:0] csr_write_data;
   int                            pending_results;
   int                            failure_count;
   bit                            hold_off_request = 1'b0;
   bit                            sender_no_idle = 1'b0;
   int                            quiet_cycles = 0;

   pdf_req_if req_if ();
   pdf_rsp_if rsp_if ();

   pareto_dominance_filter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   pdf_filter_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_results  (pending_results),
      .failure_count    (failure_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // small values make ties and coverage common; extremes and full range mixed in
   function automatic logic signed [pdf_pkg::IN_COORD_W-1:0] pick_coord();
      int v;
      case ($urandom_range(0, 9))
         0: v = COORD_MIN;
         1: v = COORD_MAX;
         2, 3, 4, 5, 6: v = int'($urandom_range(0, 6)) - 3;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic offer_request(input logic [pdf_pkg::FUNC_WIDTH-1:0] func,
                                input logic [pdf_pkg::ID_WIDTH-1:0] pid,
                                input logic [pdf_pkg::OBJ_IDX_W-1:0] obj,
                                input logic signed [pdf_pkg::IN_COORD_W-1:0] value,
                                input logic [pdf_pkg::START_WIDTH-1:0] range_first,
                                input logic signed [pdf_pkg::END_WIDTH-1:0] range_last);
      int gap;
      if ($urandom_range(0, 24) == 0) sender_no_idle = !sender_no_idle;
      gap = sender_no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.func            <= func;
      req_if.point_index     <= pid;
      req_if.objective_index <= obj;
      req_if.coord_value     <= value;
      req_if.range_start     <= range_first;
      req_if.range_end       <= range_last;
      req_if.valid           <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic load_point(input int pid, input int obj, input logic signed [31:0] value);
      offer_request(pdf_pkg::FUNC_LOAD_POINT, ID_W'(pid), OBJ_W'(obj), value,
                    START_W'($urandom), END_W'($urandom));
   endtask

   task automatic load_ideal(input int obj, input logic signed [31:0] value);
      offer_request(pdf_pkg::FUNC_LOAD_IDEAL, ID_W'($urandom), OBJ_W'(obj), value,
                    START_W'($urandom), END_W'($urandom));
   endtask

   task automatic offer_run(input int range_first, input int range_last);
      offer_request(pdf_pkg::FUNC_RUN, ID_W'($urandom), OBJ_W'($urandom), $urandom,
                    START_W'(range_first), END_W'(range_last));
   endtask

   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_objective_count(input int count);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= CFG_W'(count);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // response side: random stalls, quiet stretches, one long hold-off on request
   initial begin
      int gap;
      bit no_idle;
      no_idle = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
         gap = no_idle ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   initial begin
      int phase;
      int n;
      int pid;
      int obj;
      int range_first;
      int span;
      int range_last;
      int pick;
      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_write_data         <= '0;
      req_if.valid           <= 1'b0;
      req_if.func            <= pdf_pkg::FUNC_LOAD_IDEAL;
      req_if.point_index     <= '0;
      req_if.objective_index <= '0;
      req_if.coord_value     <= '0;
      req_if.range_start     <= '0;
      req_if.range_end       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // runs stay inside the filled slots, so no run reads an unwritten entry
      for (obj = 0; obj < NUM_OBJ; obj++) load_ideal(obj, ($urandom_range(0, 1) != 0) ?
                                                     COORD_MAX : pick_coord());
      for (pid = 0; pid < FILLED_POINTS; pid++)
         for (obj = 0; obj < NUM_OBJ; obj++) load_point(pid, obj, pick_coord());

      // directed: two objectives at reset count
      load_ideal(0, COORD_MAX);
      load_ideal(1, COORD_MAX);
      load_point(0, 0, COORD_MIN);
      load_point(0, 1, COORD_MAX);
      load_point(1, 0, COORD_MAX);
      load_point(1, 1, COORD_MIN);
      load_point(2, 0, COORD_MAX);
      load_point(2, 1, COORD_MIN);
      load_point(3, 0, COORD_MIN);
      load_point(3, 1, COORD_MIN);
      offer_run(0, 3);
      offer_request(FUNC_UNUSED, ID_W'($urandom), OBJ_W'($urandom), $urandom,
                    START_W'($urandom), END_W'($urandom));
      offer_run(5, -1);
      offer_run(63, 62);
      load_point(63, 7, COORD_MAX);
      offer_run(63, 63);
      load_ideal(0, COORD_MIN);
      offer_run(0, 7);
      load_ideal(0, 0);
      offer_run(0, FILLED_POINTS - 1);
      offer_run(16, FILLED_POINTS - 1);

      for (phase = 0; phase < PHASES; phase++) begin
         write_objective_count((phase == 0) ? NUM_OBJ : (phase == 1) ? 1 :
                               $urandom_range(1, NUM_OBJ));
         if (phase == 2) begin
            hold_off_request = 1'b1;
            for (n = 0; n < 6; n++) offer_run(n * 5, n * 5 + 4);
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               load_point($urandom_range(0, NUM_POINTS - 1), $urandom_range(0, NUM_OBJ - 1),
                          pick_coord());
            end else if (pick < 52) begin
               load_ideal($urandom_range(0, NUM_OBJ - 1),
                          ($urandom_range(0, 2) == 0) ? pick_coord() : COORD_MAX);
            end else if (pick < 55) begin
               offer_request(FUNC_UNUSED, ID_W'($urandom), OBJ_W'($urandom), $urandom,
                             START_W'($urandom), END_W'($urandom));
            end else begin
               if ($urandom_range(0, 11) == 0) begin
                  span = $urandom_range(9, FILLED_POINTS);
                  range_first = $urandom_range(0, FILLED_POINTS - span);
               end else begin
                  span = $urandom_range(0, 8);
                  range_first = $urandom_range(0, FILLED_POINTS - 1);
               end
               range_last = range_first + span - 1;
               if (range_last > FILLED_POINTS - 1) range_last = FILLED_POINTS - 1;
               if ($urandom_range(0, 19) == 0)
                  range_last = (range_first == 0) ? -1 : $urandom_range(0, range_first - 1);
               offer_run(range_first, range_last);
            end
         end
      end

      wait_for_drain();
      if (failure_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
